// ===== hw/rtl/obpe_pkg.sv =====
// Shared widths, constants and codes of the oscillometric pressure estimator.
`default_nettype none

package obpe_pkg;

  localparam int unsigned RawW   = 24;
  localparam int unsigned PresW  = 20;
  localparam int unsigned DiaW   = 21;
  localparam int unsigned LevelW = 19;
  localparam int unsigned WinW   = 12;
  localparam int unsigned RateW  = 16;
  localparam int unsigned OscW   = 10;
  localparam int unsigned HrW    = 12;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Conversion: floor((raw - 419430) * 76800 / 3355443)
  //   = floor((raw - 419430) * 384000 / (2^24 - 1)).
  // A bias of 16384 * (2^24 - 1) keeps the dividend positive.
  localparam int unsigned ProdW   = 43;
  localparam int unsigned DivShft = 24;
  localparam int unsigned QuotW   = ProdW - DivShft;
  localparam logic [ProdW-1:0]        ConvScale = 43'd384000;
  localparam logic [ProdW-1:0]        ConvBias  = 43'd113816770560;
  localparam logic signed [PresW-1:0] QuotBias  = 20'sd16384;

  // Reset values of the configuration registers
  localparam logic [LevelW-1:0] StartLevelRst = 19'd40960;
  localparam logic [LevelW-1:0] BandHighRst   = 19'd30720;
  localparam logic [LevelW-1:0] BandLowRst    = 19'd15360;
  localparam logic [WinW-1:0]   WindowRst     = 12'd150;
  localparam logic [RateW-1:0]  FastRateRst   = 16'd154;
  localparam logic [RateW-1:0]  SlowRateRst   = 16'd51;

  // Reset values of the tracking state
  localparam logic signed [PresW-1:0] LastPresRst = 20'sd38400;
  localparam logic signed [PresW-1:0] LocalMaxRst = -20'sd2560;
  localparam logic signed [PresW-1:0] LocalMinRst = 20'sd256000;
  localparam logic [OscW-1:0]         OscMax      = 10'd1023;

  // Range of a converted pressure
  localparam logic signed [PresW-1:0] PresMin = -20'sd9600;
  localparam logic signed [PresW-1:0] PresMax = 20'sd374400;

  typedef enum logic [1:0] {
    RATE_FAST   = 2'd0,
    RATE_SLOW   = 2'd1,
    RATE_RISING = 2'd2,
    RATE_RIGHT  = 2'd3
  } rate_class_e;

  typedef enum logic [2:0] {
    REG_START_LEVEL = 3'd0,
    REG_BAND_HIGH   = 3'd1,
    REG_BAND_LOW    = 3'd2,
    REG_WINDOW      = 3'd3,
    REG_FAST_RATE   = 3'd4,
    REG_SLOW_RATE   = 3'd5
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== hw/rtl/oscillometric_bp_estimator_core.sv =====
// Stages: input register, constant multiply, reciprocal fold, then the tracking update
// that is also the result register.
// Throughput: one item per cycle; the result register is the tracking state, so a
// stalled result holds the pipeline only once all three earlier stages are full.
// Reset: asynchronous, active low; clears all stage valids, restores the register
// defaults and the tracking state. No clearing pass.
`default_nettype none

module oscillometric_bp_estimator_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [obpe_pkg::AddrW-1:0]          paddr,
  input  wire logic [obpe_pkg::DataW-1:0]          pwdata,
  output logic      [obpe_pkg::DataW-1:0]          prdata,
  output logic                                     pready,
  // sample channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [obpe_pkg::RawW-1:0]           raw_counts_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [obpe_pkg::PresW-1:0]        pressure_now_o,
  output logic        [1:0]                        rate_class_o,
  output logic signed [obpe_pkg::PresW-1:0]        systolic_o,
  output logic signed [obpe_pkg::DiaW-1:0]         diastolic_o,
  output logic        [obpe_pkg::HrW-1:0]          heart_rate_bpm_o
);
  import obpe_pkg::*;

  // configuration registers
  logic [LevelW-1:0] start_level_q, band_high_q, band_low_q;
  logic [WinW-1:0]   window_q;
  logic [RateW-1:0]  fast_rate_q, slow_rate_q;
  reg_idx_e          reg_idx;
  logic              cfg_write;

  // pipeline
  logic                       v1_q, v2_q, v3_q, v4_q;
  logic                       rdy1, rdy2, rdy3, rdy4, upd;
  logic [RawW-1:0]            raw_q;
  logic [ProdW-1:0]           prod_d, prod_q, fold;
  logic [QuotW-1:0]           quot;
  logic signed [PresW-1:0]    pres_d, pres_q;

  // tracking state
  logic signed [PresW-1:0]    last_pres_q, first_peak_q, first_peak_d;
  logic signed [PresW-1:0]    local_max_q, local_max_d, local_min_q, local_min_d;
  logic signed [PresW-1:0]    best_peak_q, best_peak_d;
  logic signed [DiaW-1:0]     best_swing_q, best_swing_d;
  logic                       slope_pos_q, slope_neg_q;
  logic                       armed_q, armed_d, at_peak_q, at_peak_d;
  logic                       first_found_q, first_found_d;
  logic [WinW-1:0]            tick_q, tick_d;
  logic [OscW-1:0]            osc_q, osc_d, osc_inc, beat_q, beat_d;
  rate_class_e                cls_q, cls_d;

  // update terms
  logic signed [DiaW-1:0]     cur_x, prev_x, drop, slope, swing;
  logic signed [DiaW-1:0]     start_x, high_x, low_x, fast_x, slow_x;
  logic                       in_band, detect, tick_hit;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_START_LEVEL: prdata = DataW'(start_level_q);
      REG_BAND_HIGH:   prdata = DataW'(band_high_q);
      REG_BAND_LOW:    prdata = DataW'(band_low_q);
      REG_WINDOW:      prdata = DataW'(window_q);
      REG_FAST_RATE:   prdata = DataW'(fast_rate_q);
      REG_SLOW_RATE:   prdata = DataW'(slow_rate_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_level_q <= StartLevelRst;
      band_high_q   <= BandHighRst;
      band_low_q    <= BandLowRst;
      window_q      <= WindowRst;
      fast_rate_q   <= FastRateRst;
      slow_rate_q   <= SlowRateRst;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_START_LEVEL: start_level_q <= pwdata[LevelW-1:0];
        REG_BAND_HIGH:   band_high_q   <= pwdata[LevelW-1:0];
        REG_BAND_LOW:    band_low_q    <= pwdata[LevelW-1:0];
        REG_WINDOW:      window_q      <= pwdata[WinW-1:0];
        REG_FAST_RATE:   fast_rate_q   <= pwdata[RateW-1:0];
        REG_SLOW_RATE:   slow_rate_q   <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow ----------------
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign upd        = rdy4 && v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Division by 2^24-1: q = (x + (x >> 24) + 1) >> 24, exact while q <= 2^24.
  assign prod_d = raw_q * ConvScale[18:0] + ConvBias;
  assign fold   = prod_q + ProdW'(prod_q[ProdW-1:DivShft]) + ProdW'(1);
  assign quot   = fold[ProdW-1:DivShft];
  assign pres_d = $signed({1'b0, quot}) - QuotBias;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) raw_q  <= raw_counts_i;
    if (rdy2 && v1_q)       prod_q <= prod_d;
    if (rdy3 && v2_q)       pres_q <= pres_d;
  end

  // ---------------- tracking update ----------------
  assign cur_x   = DiaW'(pres_q);
  assign prev_x  = DiaW'(last_pres_q);
  assign start_x = $signed(DiaW'(start_level_q));
  assign high_x  = $signed(DiaW'(band_high_q));
  assign low_x   = $signed(DiaW'(band_low_q));
  assign fast_x  = $signed(DiaW'(fast_rate_q));
  assign slow_x  = $signed(DiaW'(slow_rate_q));
  assign drop    = prev_x - cur_x;
  assign slope   = cur_x - prev_x;
  assign in_band = (cur_x < high_x) && (cur_x > low_x);

  always_comb begin
    if (drop > fast_x) begin
      cls_d = RATE_FAST;
    end else if (drop < slow_x && drop > 0) begin
      cls_d = RATE_SLOW;
    end else if (drop < 0) begin
      cls_d = RATE_RISING;
    end else begin
      cls_d = RATE_RIGHT;
    end
  end

  always_comb begin
    armed_d       = armed_q || (cur_x > start_x);
    detect        = armed_d && (cur_x < start_x);
    at_peak_d     = at_peak_q;
    local_min_d   = local_min_q;
    local_max_d   = local_max_q;
    first_found_d = first_found_q;
    first_peak_d  = first_peak_q;
    osc_inc       = osc_q;
    if (detect) begin
      if (slope > 0 && slope_neg_q) begin
        at_peak_d   = 1'b0;
        local_min_d = last_pres_q;
      end else if (slope < 0 && slope_pos_q) begin
        at_peak_d = 1'b1;
        if (in_band && osc_q != OscMax) osc_inc = osc_q + OscW'(1);
        if (!first_found_q) begin
          first_peak_d  = last_pres_q;
          first_found_d = 1'b1;
        end
        local_max_d = last_pres_q;
      end
    end
    swing        = DiaW'(local_max_d) - DiaW'(local_min_d);
    best_swing_d = best_swing_q;
    best_peak_d  = best_peak_q;
    if (detect && at_peak_d && swing > best_swing_q) begin
      best_swing_d = swing;
      best_peak_d  = local_max_d;
    end
    // window end: latch the beat count only while in band
    tick_hit = (tick_q == window_q);
    osc_d    = osc_inc;
    beat_d   = beat_q;
    if (tick_hit && in_band) begin
      beat_d = osc_inc;
      osc_d  = '0;
    end
    tick_d = (tick_hit ? '0 : tick_q) + WinW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pres_q   <= LastPresRst;
      slope_pos_q   <= 1'b0;
      slope_neg_q   <= 1'b0;
      armed_q       <= 1'b0;
      at_peak_q     <= 1'b0;
      first_found_q <= 1'b0;
      first_peak_q  <= '0;
      local_max_q   <= LocalMaxRst;
      local_min_q   <= LocalMinRst;
      best_swing_q  <= '0;
      best_peak_q   <= '0;
      tick_q        <= '0;
      osc_q         <= '0;
      beat_q        <= '0;
      cls_q         <= RATE_RIGHT;
    end else if (upd) begin
      last_pres_q   <= pres_q;
      slope_pos_q   <= slope > 0;
      slope_neg_q   <= slope[DiaW-1];
      armed_q       <= armed_d;
      at_peak_q     <= at_peak_d;
      first_found_q <= first_found_d;
      first_peak_q  <= first_peak_d;
      local_max_q   <= local_max_d;
      local_min_q   <= local_min_d;
      best_swing_q  <= best_swing_d;
      best_peak_q   <= best_peak_d;
      tick_q        <= tick_d;
      osc_q         <= osc_d;
      beat_q        <= beat_d;
      cls_q         <= cls_d;
    end
  end

  // The tracking state only advances when the result slot frees, so it is the result.
  assign out_valid_o      = v4_q;
  assign pressure_now_o   = last_pres_q;
  assign rate_class_o     = cls_q;
  assign systolic_o       = first_peak_q;
  assign diastolic_o      = {best_peak_q, 1'b0} - DiaW'(first_peak_q);
  assign heart_rate_bpm_o = {beat_q, 2'b00};

endmodule

`default_nettype wire

// ===== hw/rtl/obpe_checker.sv =====
// Port-level checks of the oscillometric pressure estimator, bound to the top level.
`default_nettype none

module obpe_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [obpe_pkg::AddrW-1:0]          paddr,
  input  wire logic [obpe_pkg::DataW-1:0]          pwdata,
  input  wire logic [obpe_pkg::DataW-1:0]          prdata,
  input  wire logic                                pready,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_o,
  input  wire logic [obpe_pkg::RawW-1:0]           raw_counts_i,
  input  wire logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  input  wire logic signed [obpe_pkg::PresW-1:0]   pressure_now_o,
  input  wire logic        [1:0]                   rate_class_o,
  input  wire logic signed [obpe_pkg::PresW-1:0]   systolic_o,
  input  wire logic signed [obpe_pkg::DiaW-1:0]    diastolic_o,
  input  wire logic        [obpe_pkg::HrW-1:0]     heart_rate_bpm_o
);
  import obpe_pkg::*;

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a stalled item holds its valid and payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressure_now_o)
      && $stable(rate_class_o) && $stable(systolic_o) && $stable(diastolic_o)
      && $stable(heart_rate_bpm_o))
    else $error("stalled result changed");

  // an offered sample waits unchanged until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(raw_counts_i))
    else $error("offered sample dropped or changed");

  // a start level write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == '0
      |=> paddr != '0 || prdata[LevelW-1:0] == $past(pwdata[LevelW-1:0]))
    else $error("start level readback mismatch");

  // converted pressure stays in the sensor span and the rate is a multiple of four
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pressure_now_o >= PresMin && pressure_now_o <= PresMax
      && heart_rate_bpm_o[1:0] == 2'b00)
    else $error("result out of range");

endmodule

bind oscillometric_bp_estimator_core obpe_checker u_obpe_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the oscillometric pressure estimator core.
`timescale 1ns / 1ps

module tb;
  import obpe_pkg::*;

  localparam longint SensorOffset = 419430;
  localparam longint SensorSpan   = 3355443;
  localparam longint ScaleNum     = 76800;
  localparam int     BeatScale    = 4;
  localparam int     RawMax       = 16777215;
  localparam int     PresTop      = 374400;
  localparam int     PresFloor    = -9000;
  localparam int     CfgLevelTop  = 374304;
  localparam int     NumRegs      = 6;
  localparam int     QuietLimit   = 1000;
  localparam int     MaxLogged    = 100;
  localparam int     NumProbes    = 20;

  typedef struct packed {
    logic signed [PresW-1:0] pressure;
    rate_class_e             rate;
    logic signed [PresW-1:0] systolic;
    logic signed [DiaW-1:0]  diastolic;
    logic [HrW-1:0]          heart_rate;
  } bp_reading_t;

  typedef struct packed {
    logic [RawW-1:0] raw;
    logic            pinned;
    bp_reading_t     want;
  } probe_t;

  typedef enum logic [1:0] {
    SINK_OPEN, SINK_EVERY_THIRD, SINK_COIN, SINK_BURSTY
  } sink_mode_e;

  localparam bp_reading_t NoReading = '0;

  // Reset, both extremes of the sensor, then a slow deflation with a few beats.
  probe_t probes [NumProbes] = '{
    '{24'd419430,   1'b1, '{20'sd0, RATE_FAST, 20'sd0, 21'sd0, 12'd0}},
    '{24'd0,        1'b1, '{-20'sd9600, RATE_FAST, 20'sd0, 21'sd0, 12'd0}},
    '{24'd16777215, 1'b1, '{20'sd374400, RATE_RISING, 20'sd0, 21'sd0, 12'd0}},
    '{24'd2320848,  1'b0, NoReading},
    '{24'd2097152,  1'b0, NoReading},
    '{24'd2093796,  1'b0, NoReading},
    '{24'd2092678,  1'b0, NoReading},
    '{24'd2102744,  1'b0, NoReading},
    '{24'd2085967,  1'b0, NoReading},
    '{24'd2085967,  1'b0, NoReading},
    '{24'd1537911,  1'b0, NoReading},
    '{24'd1549096,  1'b0, NoReading},
    '{24'd1526726,  1'b0, NoReading},
    '{24'd1537911,  1'b0, NoReading},
    '{24'd1515541,  1'b0, NoReading},
    '{24'd1526726,  1'b0, NoReading},
    '{24'd1504357,  1'b0, NoReading},
    '{24'd1761608,  1'b0, NoReading},
    '{24'd419429,   1'b0, NoReading},
    '{24'd419430,   1'b0, NoReading}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [RawW-1:0]   raw_counts_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [PresW-1:0] pressure_now_o;
  logic [1:0]              rate_class_o;
  logic signed [PresW-1:0] systolic_o;
  logic signed [DiaW-1:0]  diastolic_o;
  logic [HrW-1:0]          heart_rate_bpm_o;

  oscillometric_bp_estimator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_counts_i     (raw_counts_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pressure_now_o   (pressure_now_o),
    .rate_class_o     (rate_class_o),
    .systolic_o       (systolic_o),
    .diastolic_o      (diastolic_o),
    .heart_rate_bpm_o (heart_rate_bpm_o)
  );

  // register mirror
  logic [LevelW-1:0] cfg_start     = StartLevelRst;
  logic [LevelW-1:0] cfg_band_high = BandHighRst;
  logic [LevelW-1:0] cfg_band_low  = BandLowRst;
  logic [WinW-1:0]   cfg_window    = WindowRst;
  logic [RateW-1:0]  cfg_fast      = FastRateRst;
  logic [RateW-1:0]  cfg_slow      = SlowRateRst;

  // tracking state of the predictor
  logic signed [PresW-1:0] trk_last_p     = LastPresRst;
  logic signed [PresW-1:0] trk_last_slope = '0;
  logic                    trk_armed      = 1'b0;
  logic                    trk_at_peak    = 1'b0;
  logic                    trk_first_seen = 1'b0;
  logic signed [PresW-1:0] trk_first_peak = '0;
  logic signed [PresW-1:0] trk_local_max  = LocalMaxRst;
  logic signed [PresW-1:0] trk_local_min  = LocalMinRst;
  logic signed [DiaW-1:0]  trk_best_swing = '0;
  logic signed [PresW-1:0] trk_best_peak  = '0;
  logic [WinW-1:0]         trk_ticks      = '0;
  logic [OscW-1:0]         trk_osc        = '0;
  logic [OscW-1:0]         trk_beats      = '0;

  bp_reading_t       readings_due [$];
  logic [DataW-1:0]  plan [NumRegs];
  logic              probe_pinned;
  bp_reading_t       probe_want;
  int                fault_count  = 0;
  int unsigned       quiet_cycles = 0;
  int                results_seen = 0;
  int                burst_left;
  int                gap_max;
  logic [9:0]        sink_cycle   = '0;
  int                hold_left    = 0;
  logic              hold_level   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int counts_to_pressure(input logic [RawW-1:0] raw);
    longint scaled;
    scaled = (longint'(raw) - SensorOffset) * ScaleNum;
    if (scaled >= 0) return int'(scaled / SensorSpan);
    return -int'((-scaled + SensorSpan - 1) / SensorSpan);
  endfunction

  function automatic logic [RawW-1:0] counts_for(input int p);
    longint c;
    c = SensorOffset + (longint'(p) * SensorSpan) / ScaleNum;
    if (c < 0) c = 0;
    if (c > RawMax) c = RawMax;
    return c[RawW-1:0];
  endfunction

  task automatic log_fault(input string msg);
    if (fault_count < MaxLogged) $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  // Advance the tracker by one sample and return the reading it produces.
  task automatic track_sample(input logic [RawW-1:0] raw, output bp_reading_t r);
    int          cur;
    int          prev;
    int          drop;
    int          slope;
    int          swing;
    logic        in_band;
    rate_class_e cls;
    cur     = counts_to_pressure(raw);
    prev    = trk_last_p;
    drop    = prev - cur;
    slope   = cur - prev;
    in_band = cur < int'(cfg_band_high) && cur > int'(cfg_band_low);
    if (drop > int'(cfg_fast)) cls = RATE_FAST;
    else if (drop < int'(cfg_slow) && drop > 0) cls = RATE_SLOW;
    else if (drop < 0) cls = RATE_RISING;
    else cls = RATE_RIGHT;

    if (cur > int'(cfg_start)) trk_armed = 1'b1;
    if (trk_armed && cur < int'(cfg_start)) begin
      if (slope > 0 && trk_last_slope < 0) begin
        trk_at_peak   = 1'b0;
        trk_local_min = prev;
      end else if (slope < 0 && trk_last_slope > 0) begin
        trk_at_peak = 1'b1;
        if (in_band && trk_osc < OscMax) trk_osc++;
        if (!trk_first_seen) begin
          trk_first_peak = prev;
          trk_first_seen = 1'b1;
        end
        trk_local_max = prev;
      end
      if (trk_at_peak) begin
        swing = trk_local_max - trk_local_min;
        if (swing > trk_best_swing) begin
          trk_best_peak  = trk_local_max;
          trk_best_swing = swing;
        end
      end
    end

    // window end: take the beat count only when the sample lies in the band
    if (trk_ticks == cfg_window) begin
      if (in_band) begin
        trk_beats = trk_osc;
        trk_osc   = '0;
      end
      trk_ticks = '0;
    end
    trk_ticks++;
    trk_last_p     = cur;
    trk_last_slope = slope;

    r.pressure   = cur;
    r.rate       = cls;
    r.systolic   = trk_first_peak;
    r.diastolic  = 2 * trk_best_peak - trk_first_peak;
    r.heart_rate = trk_beats * BeatScale;
  endtask

  always @(posedge clk_i) begin : scoreboard
    bp_reading_t fresh;
    bp_reading_t want;
    logic        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_sample(raw_counts_i, fresh);
        readings_due.push_back(probe_pinned ? probe_want : fresh);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        results_seen++;
        if (readings_due.size() == 0) begin
          log_fault($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = readings_due.pop_front();
          if (pressure_now_o !== want.pressure)
            log_fault($sformatf("result %0d pressure_now %0d, expected %0d",
                                results_seen, pressure_now_o, want.pressure));
          if (rate_class_o !== want.rate)
            log_fault($sformatf("result %0d rate_class %0d, expected %0d",
                                results_seen, rate_class_o, want.rate));
          if (systolic_o !== want.systolic)
            log_fault($sformatf("result %0d systolic %0d, expected %0d",
                                results_seen, systolic_o, want.systolic));
          if (diastolic_o !== want.diastolic)
            log_fault($sformatf("result %0d diastolic %0d, expected %0d",
                                results_seen, diastolic_o, want.diastolic));
          if (heart_rate_bpm_o !== want.heart_rate)
            log_fault($sformatf("result %0d heart_rate %0d, expected %0d",
                                results_seen, heart_rate_bpm_o, want.heart_rate));
        end
      end
      if (psel && penable && pready) moved = 1'b1;
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("oscillometric_bp_estimator_core regression: fail");
    $finish;
  end

  // result side: cycle through open, patterned, coin-toss and bursty stalling
  always @(negedge clk_i) begin : result_sink
    sink_cycle++;
    case (sink_mode_e'(sink_cycle[9:8]))
      SINK_OPEN:        out_ready_i = 1'b1;
      SINK_EVERY_THIRD: out_ready_i = (sink_cycle % 3) != 0;
      SINK_COIN:        out_ready_i = 1'($urandom_range(0, 1));
      default: begin
        if (hold_left == 0) begin
          hold_left  = $urandom_range(1, 16);
          hold_level = ~hold_level;
        end
        hold_left--;
        out_ready_i = hold_level;
      end
    endcase
  end

  // Offer one item and hold it until taken; gaps fall between bursts.
  task automatic send_sample(input logic [RawW-1:0] raw, input logic pin,
                             input bp_reading_t want);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    raw_counts_i = raw;
    probe_pinned = pin;
    probe_want   = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and drain every outstanding reading.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] kept;
    logic [DataW-1:0] readback;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_START_LEVEL: begin
        cfg_start = value[LevelW-1:0];
        kept      = DataW'(cfg_start);
      end
      REG_BAND_HIGH: begin
        cfg_band_high = value[LevelW-1:0];
        kept          = DataW'(cfg_band_high);
      end
      REG_BAND_LOW: begin
        cfg_band_low = value[LevelW-1:0];
        kept         = DataW'(cfg_band_low);
      end
      REG_WINDOW: begin
        cfg_window = value[WinW-1:0];
        kept       = DataW'(cfg_window);
      end
      REG_FAST_RATE: begin
        cfg_fast = value[RateW-1:0];
        kept     = DataW'(cfg_fast);
      end
      default: begin
        cfg_slow = value[RateW-1:0];
        kept     = DataW'(cfg_slow);
      end
    endcase
    // read back through a fresh setup and access
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== kept)
      log_fault($sformatf("register %s read %0h, expected %0h", idx.name(), readback, kept));
  endtask

  task automatic load_registers();
    for (int i = 0; i < NumRegs; i++) program_reg(reg_idx_e'(i), plan[i]);
  endtask

  task automatic random_plan();
    plan[REG_START_LEVEL] = $urandom_range(25600, 51200);
    plan[REG_BAND_HIGH]   = $urandom_range(20480, 35840);
    plan[REG_BAND_LOW]    = $urandom_range(5120, 20480);
    plan[REG_WINDOW]      = $urandom_range(1, 200);
    plan[REG_FAST_RATE]   = $urandom_range(64, 640);
    plan[REG_SLOW_RATE]   = $urandom_range(0, plan[REG_FAST_RATE]);
  endtask

  // Mostly deflation runs from just above the start level, with beats on top;
  // the rest is raw noise over the whole sensor range.
  task automatic deflate(input int items);
    int sent;
    int base;
    int p;
    int step_max;
    int amp;
    int half;
    int jitter;
    int len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_sample(RawW'($urandom_range(0, RawMax)), 1'b0, NoReading);
          sent++;
        end
      end else begin
        base = int'(cfg_start) + int'($urandom_range(256, 8000));
        if (base > PresTop) base = PresTop;
        case ($urandom_range(0, 2))
          0:       step_max = 60;
          1:       step_max = 200;
          default: step_max = 700;
        endcase
        amp    = $urandom_range(0, 1200);
        half   = $urandom_range(1, 6);
        jitter = $urandom_range(0, 30);
        len    = $urandom_range(16, 150);
        for (int k = 0; k < len && sent < items && base > PresFloor; k++) begin
          p = base + (((k / half) % 2) != 0 ? amp : 0) + int'($urandom_range(0, jitter));
          send_sample(counts_for(p), 1'b0, NoReading);
          sent++;
          base -= int'($urandom_range(0, step_max));
        end
      end
    end
  endtask

  // Alternate a high and an in-band low sample so that every low one is a beat.
  task automatic saturate_beats(input int pairs);
    int floor_p;
    floor_p = int'(cfg_band_low) + 64;
    repeat (pairs) begin
      send_sample(counts_for(floor_p + int'($urandom_range(200, 1500))), 1'b0, NoReading);
      send_sample(counts_for(floor_p + int'($urandom_range(0, 40))), 1'b0, NoReading);
    end
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    raw_counts_i = '0;
    probe_pinned = 1'b0;
    probe_want   = NoReading;
    burst_left   = 0;
    gap_max      = 3;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probes[i]) send_sample(probes[i].raw, probes[i].pinned, probes[i].want);
    settle();

    gap_max = 0;
    deflate(150);
    settle();

    random_plan();
    load_registers();
    gap_max = 6;
    deflate(150);
    settle();

    plan[REG_START_LEVEL] = CfgLevelTop;
    plan[REG_BAND_HIGH]   = CfgLevelTop;
    plan[REG_BAND_LOW]    = 0;
    plan[REG_WINDOW]      = 4095;
    plan[REG_FAST_RATE]   = 65535;
    plan[REG_SLOW_RATE]   = 65535;
    load_registers();
    gap_max = 2;
    deflate(80);
    settle();

    // window drops below the running count here
    plan[REG_START_LEVEL] = 0;
    plan[REG_BAND_HIGH]   = 0;
    plan[REG_BAND_LOW]    = 0;
    plan[REG_WINDOW]      = 1;
    plan[REG_FAST_RATE]   = 0;
    plan[REG_SLOW_RATE]   = 0;
    load_registers();
    gap_max = 4;
    deflate(80);
    settle();

    // out-of-range writes: only the low bits of each register survive
    foreach (plan[i]) plan[i] = '1;
    load_registers();
    gap_max = 0;
    deflate(60);
    settle();

    random_plan();
    plan[REG_WINDOW] = 0;
    load_registers();
    gap_max = 5;
    deflate(100);
    settle();

    random_plan();
    load_registers();
    gap_max = 8;
    deflate(100);
    settle();

    // hold the window end off for a full wrap while beats pile up
    plan[REG_START_LEVEL] = DataW'(StartLevelRst);
    plan[REG_BAND_HIGH]   = DataW'(BandHighRst);
    plan[REG_BAND_LOW]    = DataW'(BandLowRst);
    plan[REG_WINDOW]      = DataW'(WinW'(trk_ticks - 1'b1));
    plan[REG_FAST_RATE]   = DataW'(FastRateRst);
    plan[REG_SLOW_RATE]   = DataW'(SlowRateRst);
    load_registers();
    gap_max = 2;
    saturate_beats(150);
    settle();

    // close the window on an in-band sample to publish the full count
    program_reg(REG_WINDOW, DataW'(trk_ticks));
    saturate_beats(1);
    deflate(30);
    settle();

    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("oscillometric_bp_estimator_core regression: pass");
    end else begin
      $display("oscillometric_bp_estimator_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/obpe_pkg.sv
hw/rtl/oscillometric_bp_estimator_core.sv
hw/rtl/obpe_checker.sv
bench/tb.sv
